### sv/jul_pkg.sv
// ---------------------------------------------------------------------------
// Julia escape-time pixel core: shared types and constants
// Payload structs, configuration struct, sequencer states, register indexes
// and the 32-bit saturation helper used by the datapath.
// ---------------------------------------------------------------------------
package jul_pkg;

	localparam int FRAC_BITS = 28;
	localparam int ESC_BIT   = 58;          // |z|^2 >= 4.0 in Q8.56
	localparam int APB_AW    = 5;
	localparam int GRAY_FULL = 250;
	localparam int CNT_SAT   = 63;
	localparam logic signed [29:0] C_RESET = 30'sd187904819;

	typedef struct packed {
		logic [11:0] pixel_x;
		logic [11:0] pixel_y;
	} pixel_t;

	typedef struct packed {
		logic [5:0] iteration_count;
		logic [7:0] gray_level;
	} result_t;

	typedef struct packed {
		logic signed [29:0] c_real;
		logic signed [29:0] c_imag;
		logic signed [31:0] origin_x;
		logic signed [31:0] origin_y;
		logic [28:0]        step_x;
		logic [28:0]        step_y;
	} cfg_t;

	typedef enum logic [2:0] {
		REG_C_REAL   = 3'd0,
		REG_C_IMAG   = 3'd1,
		REG_ORIGIN_X = 3'd2,
		REG_ORIGIN_Y = 3'd3,
		REG_STEP_X   = 3'd4,
		REG_STEP_Y   = 3'd5
	} reg_idx_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MUL_X,
		ST_MUL_Y,
		ST_LOAD_Y,
		ST_SQ_R,
		ST_SQ_I,
		ST_CROSS,
		ST_UPDATE
	} st_t;

	function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
		logic signed [31:0] r;
		if (v[63:31] == '0 || v[63:31] == '1) begin
			r = v[31:0];
		end else if (v[63]) begin
			r = 32'sh8000_0000;
		end else begin
			r = 32'sh7fff_ffff;
		end
		return r;
	endfunction

endpackage

### sv/jul_regs.sv
// ---------------------------------------------------------------------------
// Julia core configuration registers
// APB-style register file holding the Julia constant, origin and step.
// ---------------------------------------------------------------------------
module jul_regs (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [jul_pkg::APB_AW-1:0] paddr,
	input  logic [31:0]                pwdata,
	output logic [31:0]                prdata,
	output jul_pkg::cfg_t              cfg
);
	import jul_pkg::*;

	logic     wr_en;
	reg_idx_t idx;
	cfg_t     cfg_q;

	assign wr_en = psel && penable && pwrite;
	assign idx   = reg_idx_t'(paddr[4:2]);
	assign cfg   = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.c_real   <= C_RESET;
			cfg_q.c_imag   <= C_RESET;
			cfg_q.origin_x <= '0;
			cfg_q.origin_y <= '0;
			cfg_q.step_x   <= '0;
			cfg_q.step_y   <= '0;
		end else if (wr_en) begin
			unique case (idx)
				REG_C_REAL:   cfg_q.c_real   <= pwdata[29:0];
				REG_C_IMAG:   cfg_q.c_imag   <= pwdata[29:0];
				REG_ORIGIN_X: cfg_q.origin_x <= pwdata;
				REG_ORIGIN_Y: cfg_q.origin_y <= pwdata;
				REG_STEP_X:   cfg_q.step_x   <= pwdata[28:0];
				REG_STEP_Y:   cfg_q.step_y   <= pwdata[28:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (idx)
			REG_C_REAL:   prdata = {{2{cfg_q.c_real[29]}}, cfg_q.c_real};
			REG_C_IMAG:   prdata = {{2{cfg_q.c_imag[29]}}, cfg_q.c_imag};
			REG_ORIGIN_X: prdata = cfg_q.origin_x;
			REG_ORIGIN_Y: prdata = cfg_q.origin_y;
			REG_STEP_X:   prdata = {3'b000, cfg_q.step_x};
			REG_STEP_Y:   prdata = {3'b000, cfg_q.step_y};
			default:      prdata = '0;
		endcase
	end

endmodule

### sv/julia_escape_time_pixel_core.sv
// The done strobe follows when the point escapes, or after MAX_ITERATIONS iterations
// when it never escapes.
// One pixel at a time; busy is low again in the cycle done is high.
// The work is sequenced on the single 32x32 multiplier: two setup products and a load step,
// then three products (zr^2, zi^2, zr*zi) and an update step per iteration.
// Reset clears the sequencer and loads the configuration defaults; results cannot stall.
// ---------------------------------------------------------------------------
// Julia escape-time pixel core
// Forms z0 from pixel coordinates, iterates z = z*z + c on a shared multiplier
// and reports the iteration count and a gray byte.
// ---------------------------------------------------------------------------
module julia_escape_time_pixel_core #(
	parameter int MAX_ITERATIONS = 50
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	output logic                       busy,
	input  jul_pkg::pixel_t            pixel,
	output logic                       done,
	output jul_pkg::result_t           result,
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [jul_pkg::APB_AW-1:0] paddr,
	input  logic [31:0]                pwdata,
	output logic [31:0]                prdata,
	output logic                       pready
);
	import jul_pkg::*;

	localparam int CNT_W  = $clog2(MAX_ITERATIONS + 1);
	localparam int GRAY_Q = GRAY_FULL / MAX_ITERATIONS;
	localparam int GRAY_R = GRAY_FULL % MAX_ITERATIONS;

	cfg_t cfg;

	st_t state_q, state_d;
	pixel_t pixel_q;
	logic signed [31:0] zr_q, zi_q;
	logic signed [63:0] prod_q, rr_q, ii_q;
	logic [CNT_W-1:0] count_q, grem_q;
	logic [7:0] gray_q;
	logic done_q;
	result_t result_q;

	logic signed [31:0] mul_a, mul_b;
	logic signed [63:0] mul_p;
	logic [63:0] mag_sum;
	logic escape, last_iter;
	logic signed [63:0] diff, nr_full, ni_full, zr_init, zi_init;
	logic [CNT_W-1:0] count_n, grem_n;
	logic [CNT_W:0] gsum;
	logic [7:0] gray_n;
	logic [8:0] cnt_ext_esc, cnt_ext_last;

	jul_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.cfg     (cfg)
	);

	assign pready = 1'b1;

	// shared multiplier, operands chosen by the sequencer
	assign mul_p = mul_a * mul_b;

	assign zr_init = {{32{cfg.origin_x[31]}}, cfg.origin_x} + prod_q;
	assign zi_init = {{32{cfg.origin_y[31]}}, cfg.origin_y} + prod_q;

	// prod_q holds zi^2 in ST_CROSS, rr_q holds zr^2
	assign mag_sum = $unsigned(rr_q) + $unsigned(prod_q);
	assign escape  = |mag_sum[63:ESC_BIT];

	// prod_q holds zr*zi in ST_UPDATE; floor(2p / 2^28) = p >>> 27
	assign diff    = rr_q - ii_q;
	assign nr_full = (diff >>> FRAC_BITS) + $signed({{34{cfg.c_real[29]}}, cfg.c_real});
	assign ni_full = (prod_q >>> (FRAC_BITS - 1))
		+ $signed({{34{cfg.c_imag[29]}}, cfg.c_imag});

	assign count_n   = count_q + 1'b1;
	assign last_iter = (count_q == CNT_W'(MAX_ITERATIONS - 1));

	// gray = count*250/MAX kept as quotient and remainder, advanced per iteration
	assign gsum = {1'b0, grem_q} + (CNT_W+1)'(GRAY_R);
	always_comb begin
		if (gsum >= (CNT_W+1)'(MAX_ITERATIONS)) begin
			grem_n = CNT_W'(gsum - (CNT_W+1)'(MAX_ITERATIONS));
			gray_n = gray_q + 8'(GRAY_Q) + 8'd1;
		end else begin
			grem_n = gsum[CNT_W-1:0];
			gray_n = gray_q + 8'(GRAY_Q);
		end
	end

	assign cnt_ext_esc  = 9'(count_q);
	assign cnt_ext_last = 9'(count_n);

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE:   if (start) state_d = ST_MUL_X;
			ST_MUL_X:  state_d = ST_MUL_Y;
			ST_MUL_Y:  state_d = ST_LOAD_Y;
			ST_LOAD_Y: state_d = ST_SQ_R;
			ST_SQ_R:   state_d = ST_SQ_I;
			ST_SQ_I:   state_d = ST_CROSS;
			ST_CROSS:  state_d = escape ? ST_IDLE : ST_UPDATE;
			ST_UPDATE: state_d = last_iter ? ST_IDLE : ST_SQ_R;
			default:   state_d = ST_IDLE;
		endcase
	end

	// sequencer outputs
	always_comb begin
		busy  = (state_q != ST_IDLE);
		mul_a = zr_q;
		mul_b = zi_q;
		unique case (state_q)
			ST_MUL_X: begin
				mul_a = {20'd0, pixel_q.pixel_x};
				mul_b = {3'd0, cfg.step_x};
			end
			ST_MUL_Y: begin
				mul_a = {20'd0, pixel_q.pixel_y};
				mul_b = {3'd0, cfg.step_y};
			end
			ST_SQ_R: begin
				mul_a = zr_q;
				mul_b = zr_q;
			end
			ST_SQ_I: begin
				mul_a = zi_q;
				mul_b = zi_q;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			done_q  <= 1'b0;
			count_q <= '0;
			grem_q  <= '0;
			gray_q  <= '0;
		end else begin
			state_q <= state_d;
			done_q  <= (state_q == ST_CROSS && escape) || (state_q == ST_UPDATE && last_iter);
			if (state_q == ST_IDLE && start) begin
				count_q <= '0;
				grem_q  <= '0;
				gray_q  <= '0;
			end
			if (state_q == ST_UPDATE) begin
				count_q <= count_n;
				grem_q  <= grem_n;
				gray_q  <= gray_n;
			end
		end
	end

	// datapath, no reset
	always_ff @(posedge clk) begin
		prod_q <= mul_p;
		if (state_q == ST_IDLE && start) pixel_q <= pixel;
		if (state_q == ST_MUL_Y) zr_q <= sat32(zr_init);
		if (state_q == ST_LOAD_Y) zi_q <= sat32(zi_init);
		if (state_q == ST_SQ_I) rr_q <= prod_q;
		if (state_q == ST_CROSS) ii_q <= prod_q;
		if (state_q == ST_UPDATE) begin
			zr_q <= sat32(nr_full);
			zi_q <= sat32(ni_full);
		end
		if (state_q == ST_CROSS && escape) begin
			result_q.iteration_count <= (cnt_ext_esc > 9'(CNT_SAT)) ? 6'(CNT_SAT)
			                                                        : cnt_ext_esc[5:0];
			result_q.gray_level <= gray_q;
		end
		if (state_q == ST_UPDATE && last_iter) begin
			result_q.iteration_count <= (cnt_ext_last > 9'(CNT_SAT)) ? 6'(CNT_SAT)
			                                                         : cnt_ext_last[5:0];
			result_q.gray_level <= gray_n;
		end
	end

	assign done   = done_q;
	assign result = result_q;

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("accepted transaction did not raise busy");

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (!busy && $past(busy)))
		else $error("result strobe outside the end of a transaction");

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		busy |-> (count_q < CNT_W'(MAX_ITERATIONS)))
		else $error("iteration count ran past the limit");

	a_gray_rem: assert property (@(posedge clk) disable iff (!arst_n)
		busy |-> (grem_q < CNT_W'(MAX_ITERATIONS)))
		else $error("gray remainder out of range");

	a_gray_range: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (result.gray_level <= 8'(GRAY_FULL)))
		else $error("gray level above full scale");

endmodule

### bench/testbench.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// Julia escape-time pixel core testbench
// Directed table of pixels and register writes, then randomized phases
// that each program a new view and constant. Every result is compared against
// a fixed expected value or a software escape-time predictor kept in step with the registers.
// ---------------------------------------------------------------------------
module testbench;
	import jul_pkg::*;

	localparam int       ITER_LIMIT   = 50;
	localparam int       LATENCY_MAX  = 4 * ITER_LIMIT + 7;
	localparam int       PHASES       = 8;
	localparam int       PHASE_ITEMS  = 100;
	localparam longint  LIMIT_CYCLES = 1_000_000;
	localparam longint unsigned ESCAPE_SQ = 64'd1 << 58;
	// register slots past the last one; writes there must change nothing
	localparam logic [2:0] REG_SPARE_LO = 3'd6;
	localparam logic [2:0] REG_SPARE_HI = 3'd7;

	typedef struct packed {
		logic        is_write;
		logic [2:0]  reg_sel;
		logic [31:0] wdata;
		pixel_t      px;
		logic        has_gold;
		result_t     gold;
	} step_row_t;

	logic              clk     = 1'b0;
	logic              arst_n  = 1'b0;
	logic              start   = 1'b0;
	logic              busy;
	pixel_t            pixel   = '0;
	logic              done;
	result_t           result;
	logic              psel    = 1'b0;
	logic              penable = 1'b0;
	logic              pwrite  = 1'b0;
	logic [APB_AW-1:0] paddr   = '0;
	logic [31:0]       pwdata  = '0;
	logic [31:0]       prdata;
	logic              pready;

	cfg_t      cfg_shadow;
	result_t   pending_results[$];
	step_row_t directed_rows[$];
	int        error_count = 0;
	longint    cycle_count = 0;
	logic      idle_on     = 1'b1;

	julia_escape_time_pixel_core #(
		.MAX_ITERATIONS(ITER_LIMIT)
	) i_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (start),
		.busy    (busy),
		.pixel   (pixel),
		.done    (done),
		.result  (result),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	always #2 clk = ~clk;

	function automatic longint clamp32(input longint v);
		longint r;
		if (v > 64'sd2147483647) begin
			r = 64'sd2147483647;
		end else if (v < -64'sd2147483648) begin
			r = -64'sd2147483648;
		end else begin
			r = v;
		end
		return r;
	endfunction

	function automatic result_t predict_escape(input pixel_t p);
		longint          zr, zi, re_next, im_next, cr, ci;
		longint unsigned mr, mi;
		int unsigned     n;
		result_t         r;
		cr = longint'($signed(cfg_shadow.c_real));
		ci = longint'($signed(cfg_shadow.c_imag));
		zr = clamp32(longint'($signed(cfg_shadow.origin_x))
			+ longint'(p.pixel_x) * longint'(cfg_shadow.step_x));
		zi = clamp32(longint'($signed(cfg_shadow.origin_y))
			+ longint'(p.pixel_y) * longint'(cfg_shadow.step_y));
		n = 0;
		while (n < ITER_LIMIT) begin
			mr = (zr < 0) ? longint'(-zr) : zr;
			mi = (zi < 0) ? longint'(-zi) : zi;
			if (mr * mr + mi * mi >= ESCAPE_SQ) break;
			// arithmetic shift rounds toward minus infinity
			re_next = ((zr * zr - zi * zi) >>> FRAC_BITS) + cr;
			im_next = ((2 * zr * zi) >>> FRAC_BITS) + ci;
			zr = clamp32(re_next);
			zi = clamp32(im_next);
			n++;
		end
		r.iteration_count = (n > CNT_SAT) ? 6'(CNT_SAT) : 6'(n);
		r.gray_level      = 8'((n * GRAY_FULL) / ITER_LIMIT);
		return r;
	endfunction

	function automatic step_row_t cfg_row(input logic [2:0] sel, input logic [31:0] data);
		step_row_t row;
		row = '0;
		row.is_write = 1'b1;
		row.reg_sel  = sel;
		row.wdata    = data;
		return row;
	endfunction

	function automatic step_row_t pixel_row(input int x, input int y);
		step_row_t row;
		row = '0;
		row.px.pixel_x = 12'(x);
		row.px.pixel_y = 12'(y);
		return row;
	endfunction

	function automatic step_row_t known_row(input int x, input int y, input int cnt,
			input int gray);
		step_row_t row;
		row = pixel_row(x, y);
		row.has_gold             = 1'b1;
		row.gold.iteration_count = 6'(cnt);
		row.gold.gray_level      = 8'(gray);
		return row;
	endfunction

	// Present one pixel until it is taken; start stays high into the next call.
	task automatic send_pixel(input pixel_t p, input logic use_gold, input result_t gold);
		pixel <= p;
		forever begin
			if (idle_on && $urandom_range(99) < 9) begin
				start <= 1'b0;
			end else begin
				start <= 1'b1;
			end
			@(posedge clk);
			if (start && !busy) break;
		end
		pending_results.push_back(use_gold ? gold : predict_escape(p));
	endtask

	task automatic drain;
		start <= 1'b0;
		@(posedge clk);
		while (pending_results.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic apb_write(input logic [2:0] sel, input logic [31:0] data);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {sel, 2'b00};
		pwdata  <= data;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		case (sel)
			REG_C_REAL:   cfg_shadow.c_real   = data[29:0];
			REG_C_IMAG:   cfg_shadow.c_imag   = data[29:0];
			REG_ORIGIN_X: cfg_shadow.origin_x = data;
			REG_ORIGIN_Y: cfg_shadow.origin_y = data;
			REG_STEP_X:   cfg_shadow.step_x   = data[28:0];
			REG_STEP_Y:   cfg_shadow.step_y   = data[28:0];
			default: ;
		endcase
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(posedge clk);
	endtask

	// Compare each done strobe with the oldest outstanding pixel.
	always @(posedge clk) begin
		result_t want;
		if (arst_n && done) begin
			if (pending_results.size() == 0) begin
				$error("result with no pixel outstanding: count %0d gray %0d",
					result.iteration_count, result.gray_level);
				error_count++;
			end else begin
				want = pending_results.pop_front();
				if (result.iteration_count !== want.iteration_count) begin
					$error("iteration_count: expected %0d, actual %0d",
						want.iteration_count, result.iteration_count);
					error_count++;
				end
				if (result.gray_level !== want.gray_level) begin
					$error("gray_level: expected %0d, actual %0d",
						want.gray_level, result.gray_level);
					error_count++;
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > LIMIT_CYCLES) begin
			$display("FAILURE");
			$finish;
		end
	end

	initial begin
		step_row_t row;
		pixel_t    p;
		int        ph, k, v;
		logic      wild;

		cfg_shadow.c_real   = C_RESET;
		cfg_shadow.c_imag   = C_RESET;
		cfg_shadow.origin_x = '0;
		cfg_shadow.origin_y = '0;
		cfg_shadow.step_x   = '0;
		cfg_shadow.step_y   = '0;

		directed_rows = '{
			// reset view: every pixel starts at zero with c = 0.7 + 0.7i
			known_row(0, 0, 3, 15),
			known_row(4095, 4095, 3, 15),
			known_row(4095, 0, 3, 15),
			known_row(0, 4095, 3, 15),
			// c = 0 with junk above the field: z stays at zero
			cfg_row(REG_C_REAL, 32'hC000_0000),
			cfg_row(REG_C_IMAG, 32'h0),
			known_row(1234, 2345, 50, 250),
			// magnitude exactly 2 escapes at once, just below does not
			cfg_row(REG_ORIGIN_X, 32'h2000_0000),
			known_row(0, 0, 0, 0),
			cfg_row(REG_ORIGIN_X, 32'h1FFF_FFFF),
			pixel_row(0, 0),
			cfg_row(REG_ORIGIN_X, 32'h7FFF_FFFF),
			known_row(0, 0, 0, 0),
			cfg_row(REG_ORIGIN_X, 32'h8000_0000),
			known_row(4095, 0, 0, 0),
			// largest step with the column product saturating
			cfg_row(REG_STEP_X, 32'hFFFF_FFFF),
			known_row(4095, 0, 0, 0),
			known_row(0, 4095, 0, 0),
			// origin -2.0 with a step of exactly one
			cfg_row(REG_ORIGIN_X, 32'hE000_0000),
			cfg_row(REG_STEP_X, 32'h1000_0000),
			known_row(2, 0, 50, 250),
			known_row(1, 0, 50, 250),
			known_row(4, 0, 0, 0),
			cfg_row(REG_ORIGIN_Y, 32'h7FFF_FFFF),
			known_row(2, 0, 0, 0),
			cfg_row(REG_ORIGIN_Y, 32'h8000_0000),
			cfg_row(REG_STEP_Y, 32'hFFFF_FFFF),
			known_row(2, 4095, 0, 0),
			known_row(2, 0, 0, 0),
			// a bounded view around the origin
			cfg_row(REG_ORIGIN_Y, 32'hF800_0000),
			cfg_row(REG_STEP_Y, 32'h0100_0000),
			cfg_row(REG_C_REAL, 32'hF400_0000),
			cfg_row(REG_C_IMAG, 32'h0200_0000),
			pixel_row(2, 8),
			pixel_row(1, 3),
			pixel_row(3, 11),
			pixel_row(2, 13),
			// constant at the field extremes
			cfg_row(REG_C_REAL, 32'h1FFF_FFFF),
			pixel_row(2, 8),
			cfg_row(REG_C_IMAG, 32'h2000_0000),
			pixel_row(1, 9),
			// spare slots must leave the view alone
			cfg_row(REG_SPARE_LO, 32'hFFFF_FFFF),
			cfg_row(REG_SPARE_HI, 32'h1234_5678),
			pixel_row(2, 8)
		};

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_rows[i]) begin
			row = directed_rows[i];
			if (row.is_write) begin
				drain();
				apb_write(row.reg_sel, row.wdata);
			end else begin
				send_pixel(row.px, row.has_gold, row.gold);
			end
		end

		for (ph = 0; ph < PHASES; ph++) begin
			drain();
			wild    = (ph % 3 == 2);
			idle_on = (ph != 5);
			for (k = 0; k < 6; k++) begin
				if (wild) begin
					v = int'($urandom());
				end else begin
					case (k)
						REG_C_REAL, REG_C_IMAG:
							v = int'($urandom_range(0, 1 << 29)) - (1 << 28);
						REG_ORIGIN_X, REG_ORIGIN_Y:
							v = -402653184 + int'($urandom_range(0, 1 << 26)) - (1 << 25);
						default:
							v = int'($urandom_range(1 << 14, 1 << 18));
					endcase
				end
				apb_write(3'(k), v);
			end
			if (wild) apb_write($urandom_range(1) ? REG_SPARE_HI : REG_SPARE_LO, $urandom());
			for (k = 0; k < PHASE_ITEMS; k++) begin
				p.pixel_x = 12'($urandom());
				p.pixel_y = 12'($urandom());
				send_pixel(p, 1'b0, '0);
			end
		end

		drain();
		repeat (LATENCY_MAX + 16) @(posedge clk);
		if (error_count == 0 && pending_results.size() == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

endmodule

### sim.f
sv/jul_pkg.sv
sv/jul_regs.sv
sv/julia_escape_time_pixel_core.sv
bench/testbench.sv
